// ----- hdl/pil_pkg.sv -----
package pil_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (FILL_W > 8) ? FILL_W : 8;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 7;
  localparam int GRP_SZ   = 8;
  localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 40;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              rd;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } cell_ctl_t;

endpackage

// ----- hdl/positional_insert_erase_list.sv -----
// Channel | Ports       | Fields (tdata, low bit first)
// input   | in_t*       | cmd[1:0], position[9:2], value[41:10], zero pad [47:42]
// result  | out_t*      | ok[0], count[7:1], read_value[39:8]
//
// Per transaction, the cell row shifts on the accept edge,
// read data passes one registered OR stage, then lands in the output register.
// One transaction in the read stage; in_tready drops while the read stage is occupied.
// A stalled result holds in the output register; the next transaction is still
// accepted and waits in the read stage.
// rst_n (sync, active low) clears length and valid flags; cell contents are kept.
module positional_insert_erase_list
  import pil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,  // cmd, position, value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata  // ok, count, read_value
);

  logic [1:0]        in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  logic              accept;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  fill_ext;

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              ok;
  cell_ctl_t         ctl;

  logic               s1_valid_r;
  logic               s1_ok_r;
  logic [COUNT_W-1:0] s1_count_r;
  logic               s1_go;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [DATA_W-1:0]  out_rd_r;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_rd;
  logic [DATA_W-1:0]               tree_rd;

  assign in_cmd   = in_tdata[1:0];
  assign in_pos   = in_tdata[9:2];
  assign in_val   = in_tdata[41:10];
  assign in_tready = !s1_valid_r;
  assign accept   = in_tvalid && in_tready;
  assign pos_ext  = CMP_W'(in_pos[POS_W-2:0]);
  assign fill_ext = CMP_W'(fill_r);

  always_comb begin
    ok       = 1'b0;
    fill_nxt = fill_r;
    ctl.op   = OP_HOLD;
    ctl.rd   = 1'b0;
    ctl.pos  = pos_ext;
    ctl.val  = in_val;
    if (accept && !in_pos[POS_W-1]) begin
      unique case (cmd_t'(in_cmd))
        CMD_INSERT: begin
          if ((fill_r < FILL_W'(CAPACITY)) && (pos_ext <= fill_ext)) begin
            ok       = 1'b1;
            fill_nxt = fill_r + 1'b1;
            ctl.op   = OP_INSERT;
          end
        end
        CMD_ERASE: begin
          if (pos_ext < fill_ext) begin
            ok       = 1'b1;
            fill_nxt = fill_r - 1'b1;
            ctl.op   = OP_ERASE;
          end
        end
        CMD_READ: begin
          if (pos_ext < fill_ext) begin
            ok     = 1'b1;
            ctl.rd = 1'b1;
          end
        end
        default: ok = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_val;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    pil_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .left_data (left_d),
      .right_data(right_d),
      .data_o    (cell_data[i]),
      .rd_o      (cell_rd[i])
    );
  end

  pil_read_tree u_tree (
    .clk   (clk),
    .en    (accept),
    .rd_in (cell_rd),
    .rd_out(tree_rd)
  );

  assign s1_go = s1_valid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r    <= ok;
      s1_count_r <= COUNT_W'(fill_nxt);
    end
    if (s1_go) begin
      out_ok_r    <= s1_ok_r;
      out_count_r <= s1_count_r;
      out_rd_r    <= tree_rd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rd_r, out_count_r, out_ok_r};

endmodule

// ----- hdl/pil_cell.sv -----
module pil_cell
  import pil_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CMP_W-1:0]  idx_c;

  assign idx_c = CMP_W'(idx);

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (idx_c == ctl.pos) begin
          data_nxt = ctl.val;
        end else if (idx_c > ctl.pos) begin
          data_nxt = left_data;
        end
      end
      OP_ERASE: begin
        if (idx_c >= ctl.pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (ctl.rd && (idx_c == ctl.pos)) ? data_r : '0;

endmodule

// ----- hdl/pil_read_tree.sv -----
module pil_read_tree
  import pil_pkg::*;
(
  input  logic                             clk,
  input  logic                             en,
  input  logic [CAPACITY-1:0][DATA_W-1:0]  rd_in,
  output logic [DATA_W-1:0]                rd_out
);

  logic [NGRP-1:0][DATA_W-1:0] grp_r;

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [DATA_W-1:0] acc;

    always_comb begin
      acc = '0;
      for (int k = 0; k < GRP_SZ; k++) begin
        if (g * GRP_SZ + k < CAPACITY) begin
          acc = acc | rd_in[g * GRP_SZ + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        grp_r[g] <= acc;
      end
    end
  end

  always_comb begin
    rd_out = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_out = rd_out | grp_r[g];
    end
  end

endmodule

// ----- hdl/pil_checker.sv -----
module pil_checker
  import pil_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while read stage busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[39:8] == '0)
    else $error("rejected transaction returned nonzero read data");

  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after accept");

endmodule

bind positional_insert_erase_list pil_checker u_pil_checker (.*);

// ----- dv/positional_insert_erase_list_tb.sv -----
module positional_insert_erase_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pil_pkg::*;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  read_value;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [DATA_W-1:0] model_entries [CAPACITY];
  int                model_len = 0;
  list_result_t      pending_results [$];
  int                error_count = 0;
  int                cycle_count = 0;
  int                rx_wait = 0;
  bit                send_burst = 1'b0;
  bit                recv_burst = 1'b0;

  positional_insert_erase_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic list_result_t list_predict(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                                                logic [DATA_W-1:0] v);
    list_result_t r;
    int pos;
    r.ok = 1'b0;
    r.read_value = '0;
    pos = int'(p);
    if (!p[POS_W-1]) begin
      case (c)
        CMD_INSERT: begin
          if (model_len < CAPACITY && pos <= model_len) begin
            for (int i = model_len; i > pos; i--) model_entries[i] = model_entries[i-1];
            model_entries[pos] = v;
            model_len++;
            r.ok = 1'b1;
          end
        end
        CMD_ERASE: begin
          if (pos < model_len) begin
            for (int i = pos; i + 1 < model_len; i++) model_entries[i] = model_entries[i+1];
            model_len--;
            r.ok = 1'b1;
          end
        end
        CMD_READ: begin
          if (pos < model_len) begin
            r.read_value = model_entries[pos];
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.count = COUNT_W'(model_len);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return '0;
    endcase
  endfunction

  // span = number of valid indices for the command
  function automatic logic [POS_W-1:0] pick_position(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && span > 0) return POS_W'($urandom_range(0, span - 1));
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return POS_W'(span);
        1: return POS_W'((span > 0) ? span - 1 : 0);
        2: return POS_W'(-1);
        default: return POS_W'(CAPACITY + 1);
      endcase
    end
    return POS_W'($urandom);
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                          input logic [DATA_W-1:0] v);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W-DATA_W-POS_W-CMD_W){1'b0}}, v, p, c};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(list_predict(c, p, v));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_cmd(CMD_READ, POS_W'(0), 32'h1234_5678);
    send_cmd(CMD_ERASE, POS_W'(0), '0);
    send_cmd(CMD_INSERT, POS_W'(1), 32'hDEAD_BEEF);
    send_cmd(CMD_INSERT, POS_W'(-1), 32'hDEAD_BEEF);
    send_cmd(CMD_UNUSED, POS_W'(0), 32'hFFFF_FFFF);
  endtask

  task automatic test_extremes_and_order();
    send_cmd(CMD_INSERT, POS_W'(0), 32'h8000_0000);
    send_cmd(CMD_INSERT, POS_W'(1), 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, POS_W'(1), 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, POS_W'(0), 32'h0000_0000);
    send_cmd(CMD_UNUSED, POS_W'(0), 32'h5555_5555);
    send_cmd(CMD_INSERT, POS_W'(-128), 32'hAAAA_AAAA);
    send_cmd(CMD_INSERT, POS_W'(CAPACITY + 1), 32'hAAAA_AAAA);
    send_cmd(CMD_READ, POS_W'(4), '0);
    send_cmd(CMD_READ, POS_W'(3), '0);
    send_cmd(CMD_READ, POS_W'(0), '0);
    send_cmd(CMD_ERASE, POS_W'(127), '0);
    send_cmd(CMD_ERASE, POS_W'(0), '0);
    send_cmd(CMD_ERASE, POS_W'(2), '0);
    send_cmd(CMD_READ, POS_W'(1), '0);
    send_cmd(CMD_ERASE, POS_W'(0), '0);
    send_cmd(CMD_READ, POS_W'(0), '0);
    send_cmd(CMD_ERASE, POS_W'(0), '0);
    send_cmd(CMD_READ, POS_W'(0), '0);
    send_cmd(CMD_UNUSED, POS_W'(-1), 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_and_drain();
    while (model_len < CAPACITY)
      send_cmd(CMD_INSERT, POS_W'($urandom_range(0, model_len)), pick_value());
    send_cmd(CMD_INSERT, POS_W'($urandom_range(0, CAPACITY)), pick_value());
    send_cmd(CMD_INSERT, POS_W'(CAPACITY), pick_value());
    send_cmd(CMD_READ, POS_W'(CAPACITY - 1), pick_value());
    send_cmd(CMD_READ, POS_W'(CAPACITY), pick_value());
    repeat (8) send_cmd(CMD_READ, POS_W'($urandom_range(0, CAPACITY - 1)), pick_value());
    while (model_len > 0)
      send_cmd(CMD_ERASE, POS_W'($urandom_range(0, model_len - 1)), pick_value());
  endtask

  task automatic test_random_ops(int n);
    int target;
    int r;
    logic [CMD_W-1:0] c;
    target = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) begin
        target = $urandom_range(0, CAPACITY);
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      if (k == n / 2) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 4) c = CMD_UNUSED;
      else if (r < 34) c = CMD_READ;
      else if (model_len < target) c = (r < 80) ? CMD_INSERT : CMD_ERASE;
      else c = (r < 80) ? CMD_ERASE : CMD_INSERT;
      send_cmd(c, pick_position((c == CMD_INSERT) ? model_len + 1 : model_len), pick_value());
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL positional_insert_erase_list");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_wait = recv_burst ? 0 : $urandom_range(0, 16);
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("[%0t] unexpected transaction: out_tdata=%h", $realtime, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.ok || out_tdata[COUNT_W:1] !== want.count ||
            out_tdata[COUNT_W+DATA_W:COUNT_W+1] !== want.read_value) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: exp ok=%0b count=%0d rd=%h, got ok=%0b count=%0d rd=%h",
                     $realtime, want.ok, want.count, want.read_value, out_tdata[0],
                     out_tdata[COUNT_W:1], out_tdata[COUNT_W+DATA_W:COUNT_W+1]);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_extremes_and_order();
    wait_idle();
    send_burst = 1'b1;
    recv_burst = 1'b1;
    test_fill_and_drain();
    wait_idle();
    send_burst = 1'b0;
    recv_burst = 1'b0;
    test_fill_and_drain();
    wait_idle();
    test_random_ops(1050);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS positional_insert_erase_list");
    end else begin
      $display("FAIL positional_insert_erase_list");
    end
    $finish;
  end

endmodule
